FILE: hw/rtl/tkn_pkg.sv
`timescale 1ns / 1ps
// Package for the newest-entries list: item types, queue entry type and fixed widths.
// Used by every module of the block; depends on nothing.
package tkn_pkg;

  localparam int LIST_SIZE_W     = 4;
  localparam int RANK_W          = 3;
  localparam int STAMP_W         = 16;
  localparam int KEY_W           = 2 * STAMP_W;
  localparam int NAME_W          = 64;
  localparam int SIZE_W          = 64;
  localparam logic [LIST_SIZE_W-1:0] LIST_SIZE_RESET = 4'd8;

  typedef struct packed {
    logic              has_candidate;
    logic              finish;
    logic [STAMP_W-1:0] created_date;
    logic [STAMP_W-1:0] created_time;
    logic [NAME_W-1:0]  name_key;
    logic [SIZE_W-1:0]  size_bytes;
  } tkn_in_t;

  typedef struct packed {
    logic              entry_valid;
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  entry_created;
    logic [NAME_W-1:0] entry_name_key;
    logic [SIZE_W-1:0] entry_size;
    logic              last_entry;
  } tkn_out_t;

  typedef struct packed {
    logic              ins;
    logic              fin;
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [SIZE_W-1:0] size;
  } tkn_op_t;

  typedef struct packed {
    logic    valid;
    tkn_op_t op;
  } tkn_q_head_t;

endpackage

FILE: hw/rtl/tkn_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, classifies them into insert and finish operations
// and holds them in a two-entry queue. Depends on tkn_pkg.
module tkn_front import tkn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  tkn_in_t     in_item,
  output tkn_q_head_t head,
  input  logic        pop
);

  tkn_op_t     q_op_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        accept;
  logic        push;
  logic        do_pop;
  tkn_op_t     op_new;

  assign busy   = (count_r == 2'd2);
  assign accept = start && !busy;

  // An item with neither a candidate nor a finish changes nothing, so it is not queued.
  assign push   = accept && (in_item.has_candidate || in_item.finish);
  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    op_new.ins  = in_item.has_candidate;
    op_new.fin  = in_item.finish;
    op_new.key  = {in_item.created_date, in_item.created_time};
    op_new.name = in_item.name_key;
    op_new.size = in_item.size_bytes;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op_r[wr_ptr_r] <= op_new;
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.op    = q_op_r[rd_ptr_r];

endmodule

FILE: hw/rtl/tkn_back.sv
`timescale 1ns / 1ps
// Back part: the sorted list with parallel compare-and-shift insertion, and the
// emission of the list one item per cycle on a finish. Depends on tkn_pkg.
module tkn_back import tkn_pkg::*; #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [LIST_SIZE_W-1:0] list_size,
  input  tkn_q_head_t            head,
  output logic                   pop,
  output logic                   out_valid,
  output tkn_out_t               out_item
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = (CNT_W > LIST_SIZE_W) ? CNT_W : LIST_SIZE_W;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [CNT_W-1:0]  rank_cnt_r, rank_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  tkn_out_t          out_item_r, out_item_nxt;

  logic [KEY_W-1:0]  slot_key_r  [MAX_ENTRIES];
  logic [NAME_W-1:0] slot_name_r [MAX_ENTRIES];
  logic [SIZE_W-1:0] slot_size_r [MAX_ENTRIES];
  logic [KEY_W-1:0]  slot_key_nxt  [MAX_ENTRIES];
  logic [NAME_W-1:0] slot_name_nxt [MAX_ENTRIES];
  logic [SIZE_W-1:0] slot_size_nxt [MAX_ENTRIES];

  logic [CNT_W-1:0]       cap;
  logic [MAX_ENTRIES-1:0] ahead;
  logic [MAX_ENTRIES-1:0] ge;
  logic [MAX_ENTRIES-1:0] below;
  logic [MAX_ENTRIES-1:0] ins_at;
  logic [MAX_ENTRIES-1:0] shift_at;
  logic                   do_ins;

  always_comb begin
    if (CAP_W'(list_size) > CAP_W'(MAX_ENTRIES)) begin
      cap = CNT_W'(MAX_ENTRIES);
    end else begin
      cap = CNT_W'(list_size);
    end
  end

  // The list stays sorted, so the entries the candidate ranks ahead of form a
  // tail; together with the unused slots that gives a thermometer code.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ahead[i] = (head.op.key > slot_key_r[i]) ||
                 ((head.op.key == slot_key_r[i]) && (head.op.name > slot_name_r[i]));
      ge[i]    = (CNT_W'(i) >= filled_r) || ahead[i];
      below[i] = (CNT_W'(i) < cap);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (i == 0) begin
        ins_at[i]   = ge[i] && below[i];
        shift_at[i] = 1'b0;
      end else begin
        ins_at[i]   = ge[i] && !ge[i-1] && below[i];
        shift_at[i] = ge[i-1] && below[i] && (CNT_W'(i) <= filled_r);
      end
    end
    do_ins = |(ge & below);
  end

  assign pop = (state_r == ST_IDLE) && head.valid;

  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    rank_cnt_nxt  = rank_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_key_nxt[i]  = slot_key_r[i];
      slot_name_nxt[i] = slot_name_r[i];
      slot_size_nxt[i] = slot_size_r[i];
    end
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          if (head.op.ins && do_ins) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (ins_at[i]) begin
                slot_key_nxt[i]  = head.op.key;
                slot_name_nxt[i] = head.op.name;
                slot_size_nxt[i] = head.op.size;
              end else if (shift_at[i] && (i > 0)) begin
                slot_key_nxt[i]  = slot_key_r[i-1];
                slot_name_nxt[i] = slot_name_r[i-1];
                slot_size_nxt[i] = slot_size_r[i-1];
              end
            end
            if (filled_r < cap) begin
              filled_nxt = filled_r + CNT_W'(1);
            end
          end
          if (head.op.fin) begin
            state_nxt    = ST_EMIT;
            rank_cnt_nxt = '0;
          end
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (filled_r == '0) begin
          out_item_nxt = '0;
          out_item_nxt.last_entry = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          // The head slot goes out and the rest of the list moves up by one.
          out_item_nxt.entry_valid    = 1'b1;
          out_item_nxt.rank           = RANK_W'(rank_cnt_r);
          out_item_nxt.entry_created  = slot_key_r[0];
          out_item_nxt.entry_name_key = slot_name_r[0];
          out_item_nxt.entry_size     = slot_size_r[0];
          out_item_nxt.last_entry     = (filled_r == CNT_W'(1));
          for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            slot_key_nxt[i]  = slot_key_r[i+1];
            slot_name_nxt[i] = slot_name_r[i+1];
            slot_size_nxt[i] = slot_size_r[i+1];
          end
          filled_nxt   = filled_r - CNT_W'(1);
          rank_cnt_nxt = rank_cnt_r + CNT_W'(1);
          if (filled_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filled_r    <= '0;
      rank_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      rank_cnt_r  <= rank_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_key_r[i]  <= slot_key_nxt[i];
      slot_name_r[i] <= slot_name_nxt[i];
      slot_size_r[i] <= slot_size_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: hw/rtl/top_k_newest_insertion.sv
`timescale 1ns / 1ps
// Top level of the newest-entries list: configuration register, front queue and back list.
// Depends on tkn_pkg, tkn_front and tkn_back.
//
// The block keeps the newest files of a scan sorted newest first. An item is taken
// whenever start is high and busy is low; busy rises only when the two-item queue
// between the front and the back is full. The back takes one queued item per cycle
// while idle; a finish makes it shift the list out entry by entry, or show the empty
// marker, and it takes no queued item meanwhile. Results appear with out_valid high for
// exactly one cycle each and cannot be held off, so the receiver must take every one.
// The list size register should only be written while no item is in flight.
module top_k_newest_insertion import tkn_pkg::*; #(
  parameter int MAX_ENTRIES = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  tkn_in_t                in_item,
  output logic                   out_valid,
  output tkn_out_t               out_item,
  input  logic                   cfg_we,
  input  logic [LIST_SIZE_W-1:0] cfg_wdata
);

  logic [LIST_SIZE_W-1:0] list_size_r, list_size_nxt;
  tkn_q_head_t            head;
  logic                   pop;

  assign list_size_nxt = cfg_we ? cfg_wdata : list_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_size_r <= LIST_SIZE_RESET;
    end else begin
      list_size_r <= list_size_nxt;
    end
  end

  tkn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  tkn_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .list_size (list_size_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: hw/rtl/tkn_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result stream and the reset state of the newest-entries list, and the bind
// that attaches them to the top level. Depends on tkn_pkg.
module tkn_checker import tkn_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     busy,
  input logic     out_valid,
  input tkn_out_t out_item
);

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.entry_valid |-> out_item.last_entry && (out_item.rank == '0))
    else $error("empty marker must be a lone result of rank zero");

  a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_entry |=> out_valid && out_item.entry_valid)
    else $error("list emission broke off before its last item");

  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_entry |=> out_item.rank == $past(out_item.rank) + 3'd1)
    else $error("rank did not advance by one within a list");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy shown straight after reset");

endmodule

bind top_k_newest_insertion tkn_checker u_tkn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

FILE: verif/tb_top_k_newest_insertion.sv
`timescale 1ns / 1ps
// Self-checking testbench for top_k_newest_insertion: directed and random scans, list size changes.
// Depends on tkn_pkg and the RTL of the block; it keeps its own model of the newest-first list.
module tb_top_k_newest_insertion;
  import tkn_pkg::*;

  localparam int MAX_ENTRIES   = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 260;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  tkn_in_t                in_item;
  logic                   out_valid;
  tkn_out_t               out_item;
  logic                   cfg_we;
  logic [LIST_SIZE_W-1:0] cfg_wdata;

  logic [KEY_W-1:0]  held_key  [MAX_ENTRIES];
  logic [NAME_W-1:0] held_name [MAX_ENTRIES];
  logic [SIZE_W-1:0] held_size [MAX_ENTRIES];
  int                held_count;
  int                keep_limit;
  tkn_out_t          expected_rows[$];

  logic [STAMP_W-1:0] recent_date;
  logic [STAMP_W-1:0] recent_time;
  logic [NAME_W-1:0]  recent_name;

  int mismatches;
  int idle_pct;
  int cycles = 0;

  top_k_newest_insertion #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit ranks_newer(int slot, logic [KEY_W-1:0] key, logic [NAME_W-1:0] nm);
    if (key != held_key[slot]) return key > held_key[slot];
    return nm > held_name[slot];
  endfunction

  function automatic void model_insert(logic [KEY_W-1:0] key, logic [NAME_W-1:0] nm,
                                       logic [SIZE_W-1:0] sz);
    int cap;
    int pos;
    int top;
    int i;
    cap = (keep_limit > MAX_ENTRIES) ? MAX_ENTRIES : keep_limit;
    if (cap == 0) return;
    pos = 0;
    while (pos < held_count && !ranks_newer(pos, key, nm)) pos++;
    if (pos >= cap) return;
    top = (held_count < cap) ? held_count : cap - 1;
    for (i = top; i > pos; i--) begin
      held_key[i]  = held_key[i-1];
      held_name[i] = held_name[i-1];
      held_size[i] = held_size[i-1];
    end
    held_key[pos]  = key;
    held_name[pos] = nm;
    held_size[pos] = sz;
    if (held_count < cap) held_count++;
  endfunction

  function automatic void update_newest_list(tkn_in_t it);
    tkn_out_t row;
    int k;
    if (it.has_candidate) begin
      model_insert({it.created_date, it.created_time}, it.name_key, it.size_bytes);
    end
    if (!it.finish) return;
    if (held_count == 0) begin
      row = '0;
      row.last_entry = 1'b1;
      expected_rows.push_back(row);
      return;
    end
    for (k = 0; k < held_count; k++) begin
      row.entry_valid    = 1'b1;
      row.rank           = k[RANK_W-1:0];
      row.entry_created  = held_key[k];
      row.entry_name_key = held_name[k];
      row.entry_size     = held_size[k];
      row.last_entry     = (k + 1 == held_count);
      expected_rows.push_back(row);
    end
    held_count = 0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    tkn_out_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (out_valid !== 1'b1) begin
        report_mismatch("out_valid", 64'(out_valid), 64'd1);
      end else if (expected_rows.size() == 0) begin
        report_mismatch("unexpected result, entry_created", 64'(out_item.entry_created), 64'd0);
      end else begin
        want = expected_rows.pop_front();
        if (out_item.entry_valid !== want.entry_valid)
          report_mismatch("entry_valid", 64'(out_item.entry_valid), 64'(want.entry_valid));
        if (out_item.rank !== want.rank)
          report_mismatch("rank", 64'(out_item.rank), 64'(want.rank));
        if (out_item.entry_created !== want.entry_created)
          report_mismatch("entry_created", 64'(out_item.entry_created),
                          64'(want.entry_created));
        if (out_item.entry_name_key !== want.entry_name_key)
          report_mismatch("entry_name_key", out_item.entry_name_key, want.entry_name_key);
        if (out_item.entry_size !== want.entry_size)
          report_mismatch("entry_size", out_item.entry_size, want.entry_size);
        if (out_item.last_entry !== want.last_entry)
          report_mismatch("last_entry", 64'(out_item.last_entry), 64'(want.last_entry));
      end
    end
  end

  task automatic send_item(input tkn_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    update_newest_list(it);
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_list_size(input logic [LIST_SIZE_W-1:0] v);
    pause_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    keep_limit = int'(v);
  endtask

  function automatic tkn_in_t make_item(logic has, logic fin, logic [STAMP_W-1:0] date,
                                        logic [STAMP_W-1:0] tod, logic [NAME_W-1:0] nm,
                                        logic [SIZE_W-1:0] sz);
    tkn_in_t it;
    it.has_candidate = has;
    it.finish        = fin;
    it.created_date  = date;
    it.created_time  = tod;
    it.name_key      = nm;
    it.size_bytes    = sz;
    return it;
  endfunction

  function automatic logic [STAMP_W-1:0] pick_stamp();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 16'h8000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h4100_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Some candidates repeat the previous stamp, or stamp and name, to exercise the tie rules.
  function automatic tkn_in_t random_candidate(logic fin);
    tkn_in_t it;
    int mode;
    mode = $urandom_range(0, 7);
    if (mode > 1) begin
      recent_date = pick_stamp();
      recent_time = pick_stamp();
    end
    if (mode != 0) recent_name = pick_name();
    it = make_item(1'b1, fin, recent_date, recent_time, recent_name, {$urandom, $urandom});
    return it;
  endfunction

  task automatic test_empty_and_ties();
    send_item(make_item(1'b0, 1'b1, '0, '0, '0, '0));
    send_item(make_item(1'b1, 1'b0, '0, '0, '0, '0));
    send_item(make_item(1'b1, 1'b0, '1, '1, '1, '1));
    send_item(make_item(1'b1, 1'b0, 16'h1234, 16'h5678, 64'h4142_4300_0000_0000, 64'd100));
    send_item(make_item(1'b1, 1'b0, 16'h1234, 16'h5678, 64'h4142_4400_0000_0000, 64'd200));
    send_item(make_item(1'b1, 1'b0, 16'h1234, 16'h5678, 64'h4142_4300_0000_0000, 64'd300));
    send_item(make_item(1'b1, 1'b1, 16'h1234, 16'h0000, 64'h5a00_0000_0000_0000, 64'd400));
    send_item(make_item(1'b0, 1'b1, '1, '1, '1, '1));
  endtask

  task automatic test_overflow();
    int i;
    for (i = 1; i <= 10; i++) begin
      send_item(make_item(1'b1, 1'b0, 16'(i), 16'(i * 7), {$urandom, $urandom}, 64'(i)));
    end
    send_item(make_item(1'b1, 1'b0, '0, '0, '0, 64'd99));
    send_item(make_item(1'b0, 1'b1, '0, '0, '0, '0));
  endtask

  task automatic test_list_sizes();
    logic [LIST_SIZE_W-1:0] sizes [5];
    int s;
    int n;
    sizes = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3};
    for (s = 0; s < 5; s++) begin
      write_list_size(sizes[s]);
      for (n = 0; n < 5; n++) send_item(random_candidate(1'b0));
      send_item(random_candidate(1'b1));
    end
  endtask

  task automatic test_shrink_mid_scan();
    int n;
    write_list_size(4'd8);
    for (n = 0; n < 6; n++) send_item(random_candidate(1'b0));
    write_list_size(4'd3);
    for (n = 0; n < 3; n++) send_item(random_candidate(1'b0));
    send_item(make_item(1'b0, 1'b1, '0, '0, '0, '0));
    write_list_size(4'd8);
  endtask

  task automatic test_random_scans();
    int sent;
    int len;
    int n;
    tkn_in_t it;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_pct = (sent > RANDOM_ITEMS * 2 / 5 && sent < RANDOM_ITEMS * 3 / 5) ? 0 : 34;
      if ($urandom_range(0, 7) == 0) begin
        write_list_size(($urandom_range(0, 1) == 0) ? 4'd8 : 4'($urandom_range(0, 15)));
      end else if ($urandom_range(0, 11) == 0) begin
        pause_until_drained();
      end
      len = $urandom_range(0, 11);
      for (n = 0; n < len; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          it = make_item(1'b0, 1'b0, 16'($urandom), 16'($urandom), {$urandom, $urandom},
                         {$urandom, $urandom});
          send_item(it);
          sent++;
        end
        send_item(random_candidate(1'b0));
        sent++;
      end
      if ($urandom_range(0, 1) == 0) begin
        send_item(random_candidate(1'b1));
      end else begin
        it = random_candidate(1'b1);
        it.has_candidate = 1'b0;
        send_item(it);
      end
      sent++;
    end
    idle_pct = 34;
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    mismatches  = 0;
    held_count  = 0;
    keep_limit  = int'(LIST_SIZE_RESET);
    idle_pct    = 34;
    recent_date = '0;
    recent_time = '0;
    recent_name = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_ties();
    test_overflow();
    test_list_sizes();
    test_shrink_mid_scan();
    test_random_scans();
    pause_until_drained();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
